FILE: src/iepad_pkg.sv
// Package for the edge-replicate padder: port widths, register indexes, controller types.
`timescale 1ns / 1ps
`default_nettype none

package iepad_pkg;

    // Input stream payload
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;

    // Result stream payload: out_rgba, out_col, out_row, padded to whole bytes
    localparam int RGBA_W     = 32;
    localparam int OUT_POS_W  = 9;
    localparam int M_TDATA_W  = 56;
    localparam int M_TDATA_PAD = M_TDATA_W - RGBA_W - 2 * OUT_POS_W;

    // Configuration port
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DIM_W    = 9;
    localparam int CFG_GUTTER_W = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GUTTER = 2'd2;

    localparam logic [CFG_DIM_W-1:0]    WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DIM_W-1:0]    HEIGHT_RESET = 9'd256;
    localparam logic [CFG_GUTTER_W-1:0] GUTTER_RESET = 5'd0;

    // Beat kinds carried in tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic do_load;
        logic do_calc;
        logic do_addr;
        logic do_read;
        logic do_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: src/iepad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module iepad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/iepad_ctrl.sv
// Controller state machine: sequences one load or emit beat through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module iepad_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_tuser,
    input  wire iepad_pkg::status_t status,
    output iepad_pkg::cmd_t        cmd
);

    import iepad_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == MODE_EMIT) ? ST_CALC : ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_CALC: state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT: begin
                // hold until the output register can take the pixel
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_LOAD: cmd.do_load = 1'b1;
            ST_CALC: cmd.do_calc = 1'b1;
            ST_ADDR: cmd.do_addr = 1'b1;
            ST_READ: cmd.do_read = 1'b1;
            ST_OUT:  cmd.do_out  = status.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/iepad_datapath.sv
// Datapath: configuration registers, load and emit counters, address arithmetic, output register.
`timescale 1ns / 1ps
`default_nettype none

module iepad_datapath #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_GUTTER = 16,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [iepad_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [iepad_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [iepad_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire iepad_pkg::cmd_t                    cmd,
    output iepad_pkg::status_t                      status,
    output logic                                    ram_wr_en,
    output logic [AW-1:0]                           ram_wr_addr,
    output logic [iepad_pkg::RGBA_W-1:0]            ram_wr_data,
    output logic                                    ram_rd_en,
    output logic [AW-1:0]                           ram_rd_addr,
    input  wire logic [iepad_pkg::RGBA_W-1:0]       ram_rd_data,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [iepad_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tlast
);

    import iepad_pkg::*;

    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int GW   = $clog2(MAX_GUTTER + 1);
    localparam int PW_W = $clog2(MAX_DIM + 2 * MAX_GUTTER + 1);
    localparam int TW   = $clog2(DEPTH + 1);
    localparam int DCW  = (CFG_DIM_W > DW) ? CFG_DIM_W : DW;
    localparam int GCW  = (CFG_GUTTER_W > GW) ? CFG_GUTTER_W : GW;

    function automatic logic [DW-1:0] dim_sat(input logic [CFG_DIM_W-1:0] v);
        logic [DCW-1:0] ve;
        ve = DCW'(v);
        if (ve == '0) begin
            return DW'(1);
        end else if (ve > DCW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(ve);
    endfunction

    function automatic logic [DW-1:0] clamp_src(input logic [PW_W-1:0] pos,
                                                input logic [GW-1:0]   g,
                                                input logic [DW-1:0]   dim);
        logic [PW_W-1:0] s;
        logic [PW_W-1:0] lim;
        s   = (pos < PW_W'(g)) ? '0 : pos - PW_W'(g);
        lim = PW_W'(dim) - PW_W'(1);
        return DW'((s > lim) ? lim : s);
    endfunction

    // Configuration
    logic [CFG_DIM_W-1:0]    image_width_reg;
    logic [CFG_DIM_W-1:0]    image_height_reg;
    logic [CFG_GUTTER_W-1:0] gutter_px_reg;

    // Values in use, re-derived from the registers every cycle
    logic [DW-1:0]   w_used;
    logic [DW-1:0]   h_used;
    logic [GW-1:0]   g_used;
    logic [PW_W-1:0] pw;
    logic [PW_W-1:0] ph;
    logic [TW-1:0]   total;
    logic [GCW-1:0]  g_ext;

    // Counters
    logic [AW-1:0]   load_idx_reg;
    logic [AW-1:0]   load_idx_next;
    logic [PW_W-1:0] emit_col_reg;
    logic [PW_W-1:0] emit_col_next;
    logic [PW_W-1:0] emit_row_reg;
    logic [PW_W-1:0] emit_row_next;

    // Beat payload and emit pipeline
    logic [RGBA_W-1:0] pixel_reg;
    logic [DW-1:0]     sx_reg;
    logic [DW-1:0]     sy_reg;
    logic [PW_W-1:0]   col_reg;
    logic [PW_W-1:0]   row_reg;
    logic              last_reg;
    logic [AW-1:0]     addr_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [RGBA_W-1:0]    out_rgba_reg;
    logic [OUT_POS_W-1:0] out_col_reg;
    logic [OUT_POS_W-1:0] out_row_reg;
    logic                 out_last_reg;

    logic [AW-1:0]     load_eff;
    logic [TW-1:0]     load_plus;
    logic [PW_W-1:0]   col_eff;
    logic [PW_W-1:0]   row_eff;
    logic [PW_W-1:0]   col_plus;
    logic [PW_W-1:0]   row_plus;
    logic [2*DW-1:0]   addr_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            gutter_px_reg    <= GUTTER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  image_width_reg  <= cfg_wdata[CFG_DIM_W-1:0];
                CFG_IDX_HEIGHT: image_height_reg <= cfg_wdata[CFG_DIM_W-1:0];
                CFG_IDX_GUTTER: gutter_px_reg    <= cfg_wdata[CFG_GUTTER_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign g_ext = GCW'(gutter_px_reg);

    always_comb begin
        w_used = dim_sat(image_width_reg);
        h_used = dim_sat(image_height_reg);
        g_used = (g_ext > GCW'(MAX_GUTTER)) ? GW'(MAX_GUTTER) : GW'(g_ext);
        pw     = PW_W'(w_used) + (PW_W'(g_used) << 1);
        ph     = PW_W'(h_used) + (PW_W'(g_used) << 1);
        total  = TW'(w_used) * TW'(h_used);
    end

    // Load: restart a stale index, write, advance and wrap
    always_comb begin
        load_eff      = (TW'(load_idx_reg) >= total) ? '0 : load_idx_reg;
        load_plus     = TW'(load_eff) + TW'(1);
        load_idx_next = (load_plus >= total) ? '0 : AW'(load_plus);
    end

    // Emit: restart a stale position, advance in raster order and wrap
    always_comb begin
        if (emit_col_reg >= pw || emit_row_reg >= ph) begin
            col_eff = '0;
            row_eff = '0;
        end else begin
            col_eff = emit_col_reg;
            row_eff = emit_row_reg;
        end
        col_plus = col_eff + PW_W'(1);
        row_plus = row_eff + PW_W'(1);
        if (col_plus >= pw) begin
            emit_col_next = '0;
            emit_row_next = (row_plus >= ph) ? '0 : row_plus;
        end else begin
            emit_col_next = col_plus;
            emit_row_next = row_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
        end else begin
            if (cmd.do_load) begin
                load_idx_reg <= load_idx_next;
            end
            if (cmd.do_calc) begin
                emit_col_reg <= emit_col_next;
                emit_row_reg <= emit_row_next;
            end
        end
    end

    assign addr_full = (2*DW)'(sy_reg) * (2*DW)'(w_used) + (2*DW)'(sx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pixel_reg <= s_tdata;
        end
        if (cmd.do_calc) begin
            sx_reg   <= clamp_src(col_eff, g_used, w_used);
            sy_reg   <= clamp_src(row_eff, g_used, h_used);
            col_reg  <= col_eff;
            row_reg  <= row_eff;
            last_reg <= (col_eff == pw - PW_W'(1)) && (row_eff == ph - PW_W'(1));
        end
        if (cmd.do_addr) begin
            addr_reg <= AW'(addr_full);
        end
    end

    assign ram_wr_en   = cmd.do_load;
    assign ram_wr_addr = load_eff;
    assign ram_wr_data = pixel_reg;
    assign ram_rd_en   = cmd.do_read;
    assign ram_rd_addr = addr_reg;

    // Output register: free when empty or when the waiting beat is taken now
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.do_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_out) begin
            out_rgba_reg <= ram_rd_data;
            out_col_reg  <= OUT_POS_W'(col_reg);
            out_row_reg  <= OUT_POS_W'(row_reg);
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_TDATA_PAD{1'b0}}, out_row_reg, out_col_reg, out_rgba_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/image_edge_replicate_padder_top.sv
// Top level of the edge-replicate image padder: controller, datapath and frame store.
`timescale 1ns / 1ps
`default_nettype none

// Loads an RGBA image in raster order (tuser = 0) into a MAX_DIM x MAX_DIM frame store,
// then on each emit beat (tuser = 1) returns the next pixel of the image padded by
// gutter_px on every side, each padded pixel copying the edge-clamped source pixel;
// tlast marks the final pixel of the padded frame. One beat is taken at a time: a
// load beat passes accept and store write; an emit beat passes accept, edge clamp,
// address multiply-add, registered store read and output register, and stalls in
// that last step while the output register stays full because m_tready is low.
// The store has one write and one read port and needs no clearing after reset;
// emitting a pixel that was never loaded returns undefined data.
module image_edge_replicate_padder_top #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_GUTTER = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration: 0 image_width, 1 image_height, 2 gutter_px
    input  wire logic                              cfg_wr_en,
    input  wire logic [iepad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [iepad_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [iepad_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] pixel_rgba
    input  wire logic [iepad_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] mode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] out_rgba, [40:32] out_col, [49:41] out_row, [55:50] zero
    output logic [iepad_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tlast    // frame_last
);

    import iepad_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t              cmd;
    status_t           status;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [RGBA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [RGBA_W-1:0] ram_rd_data;

    iepad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    iepad_datapath #(
        .MAX_DIM    (MAX_DIM),
        .MAX_GUTTER (MAX_GUTTER)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    iepad_ram #(
        .WIDTH (RGBA_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

FILE: test/tb_image_edge_replicate_padder_top.sv
// Self-checking testbench for the edge-replicate image padder: loads frames, checks padded output.
`timescale 1ns / 1ps

module tb_image_edge_replicate_padder_top;
    import iepad_pkg::*;

    localparam int unsigned PAD_MAX_DIM    = 256;
    localparam int unsigned PAD_MAX_GUTTER = 16;
    localparam int unsigned RANDOM_ITEMS   = 250;
    localparam int unsigned MAX_FRAME_LOAD = 200;

    typedef struct packed {
        logic [31:0] rgba;
        logic [8:0]  col;
        logic [8:0]  row;
        logic        last;
    } padded_px_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [31:0] pixel_rgba
    logic [S_TUSER_W-1:0]   s_tuser;   // [0] mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [31:0] out_rgba, [40:32] out_col, [49:41] out_row
    logic                   m_tlast;   // frame_last

    image_edge_replicate_padder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Shadow of the block: frame store, counters and registers
    logic [31:0]  pix_mem    [0:PAD_MAX_DIM*PAD_MAX_DIM-1];
    bit           px_written [0:PAD_MAX_DIM*PAD_MAX_DIM-1];
    int unsigned  ld_idx = 0;
    int unsigned  em_col = 0;
    int unsigned  em_row = 0;
    logic [8:0]   cfg_w  = WIDTH_RESET;
    logic [8:0]   cfg_h  = HEIGHT_RESET;
    logic [4:0]   cfg_g  = GUTTER_RESET;

    padded_px_t   expected_px[$];
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    int unsigned  n_loads   = 0;
    int unsigned  n_emits   = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_frames  = 0;
    int unsigned  n_errors  = 0;

    function automatic int unsigned dim_eff(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > PAD_MAX_DIM) return PAD_MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned gutter_eff(input logic [4:0] v);
        return (v > PAD_MAX_GUTTER) ? PAD_MAX_GUTTER : v;
    endfunction

    // Position of the next emitted pixel, restarting when it lies outside the padded frame
    function automatic void emit_start(output int unsigned col, output int unsigned row);
        int unsigned pw, ph;
        pw  = dim_eff(cfg_w) + 2 * gutter_eff(cfg_g);
        ph  = dim_eff(cfg_h) + 2 * gutter_eff(cfg_g);
        col = em_col;
        row = em_row;
        if (col >= pw || row >= ph) begin
            col = 0;
            row = 0;
        end
    endfunction

    function automatic int unsigned emit_src_addr(input int unsigned col, input int unsigned row);
        int unsigned w, h, g, sx, sy;
        w  = dim_eff(cfg_w);
        h  = dim_eff(cfg_h);
        g  = gutter_eff(cfg_g);
        sx = (col < g) ? 0 : col - g;
        sy = (row < g) ? 0 : row - g;
        if (sx > w - 1) sx = w - 1;
        if (sy > h - 1) sy = h - 1;
        return sy * w + sx;
    endfunction

    function automatic void apply_beat(input logic mode, input logic [31:0] pix);
        int unsigned w, h, pw, ph, c, r, a;
        padded_px_t px;
        w  = dim_eff(cfg_w);
        h  = dim_eff(cfg_h);
        pw = w + 2 * gutter_eff(cfg_g);
        ph = h + 2 * gutter_eff(cfg_g);
        if (mode == MODE_LOAD) begin
            if (ld_idx >= w * h) ld_idx = 0;
            pix_mem[ld_idx]    = pix;
            px_written[ld_idx] = 1'b1;
            ld_idx++;
            if (ld_idx >= w * h) ld_idx = 0;
            n_loads++;
        end else begin
            emit_start(c, r);
            a       = emit_src_addr(c, r);
            px.rgba = pix_mem[a];
            px.col  = 9'(c);
            px.row  = 9'(r);
            px.last = (c == pw - 1) && (r == ph - 1);
            expected_px = {expected_px, px};
            c++;
            if (c >= pw) begin
                c = 0;
                r++;
                if (r >= ph) r = 0;
            end
            em_col = c;
            em_row = r;
            n_emits++;
        end
    endfunction

    // Mostly no idle, often a short one, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned longest);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(longest / 3, longest);
        if (r <= 6) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [8:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r == 0) return 9'd0;
        if (r == 1) return 9'($urandom_range(257, 511));
        if (r == 2) return 9'($urandom_range(7, 24));
        if (r == 3) return 9'd256;
        return 9'($urandom_range(1, 6));
    endfunction

    function automatic logic [8:0] pick_gutter();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return 9'($urandom_range(17, 511));
        if (r == 1) return 9'd16;
        if (r == 2) return 9'($urandom_range(5, 15));
        return 9'($urandom_range(0, 4));
    endfunction

    // Write all three registers in turn: width, height, then gutter
    task automatic configure(input logic [8:0] wv, input logic [8:0] hv, input logic [8:0] gv);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_wdata <= wv;
        @(posedge aclk);
        cfg_w = wv;
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_wdata <= hv;
        @(posedge aclk);
        cfg_h = hv;
        cfg_index <= CFG_IDX_GUTTER;
        cfg_wdata <= gv;
        @(posedge aclk);
        cfg_g = gv[4:0];
        cfg_wr_en <= 1'b0;
    endtask

    // Send one beat; an emit whose source pixel was never loaded becomes a load
    task automatic push_pixel(input logic mode, input logic [31:0] pix);
        int unsigned gap, c, r;
        logic m;
        m = mode;
        if (m == MODE_EMIT) begin
            emit_start(c, r);
            if (!px_written[emit_src_addr(c, r)]) m = MODE_LOAD;
        end
        gap = tx_steady ? 0 : pick_gap(30);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        apply_beat(m, pix);
    endtask

    // Let every expected pixel arrive, then give the datapath time to settle
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic test_reset_defaults();
        // Reset geometry is 256 wide with no gutter: the first row passes straight through
        push_pixel(MODE_LOAD, 32'h0000_0000);
        push_pixel(MODE_LOAD, 32'hFFFF_FFFF);
        push_pixel(MODE_LOAD, 32'h5555_5555);
        push_pixel(MODE_LOAD, 32'hAAAA_AAAA);
        repeat (4) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
    endtask

    task automatic test_small_border();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        configure(9'd3, 9'd2, 9'd1);
        repeat (6) push_pixel(MODE_LOAD, $urandom());
        // one full padded frame plus the wrap to its start
        repeat (21) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_register_saturation();
        // zero dimensions clamp to one pixel, an oversized gutter clamps to the maximum
        configure(9'd0, 9'd0, 9'd31);
        push_pixel(MODE_LOAD, $urandom());
        repeat (34) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
        // oversized width clamps and the gutter keeps only its low five bits (16 here);
        // the padded rows then reach the top column
        configure(9'd511, 9'd2, 9'h1F0);
        repeat (256) push_pixel(MODE_LOAD, $urandom());
        repeat (289) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
        // one column, oversized height: every source row is already in the store
        configure(9'd1, 9'd300, 9'd0);
        repeat (257) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
    endtask

    task automatic test_counter_restart();
        configure(9'd8, 9'd8, 9'd0);
        repeat (40) push_pixel(MODE_LOAD, $urandom());
        repeat (10) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
        // shrink the frame: the load counter now lies beyond it and must restart
        configure(9'd4, 9'd4, 9'd0);
        repeat (5) push_pixel(MODE_EMIT, $urandom());
        repeat (3) push_pixel(MODE_LOAD, $urandom());
        repeat (12) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
        configure(9'd4, 9'd4, 9'd2);
        repeat (70) push_pixel(MODE_EMIT, $urandom());
        drain_pipeline();
    endtask

    task automatic test_random_frames();
        int unsigned done_items, frame_loads, emit_reqs, pw, ph;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) configure(pick_dim(), pick_dim(), pick_gutter());
            pw = dim_eff(cfg_w) + 2 * gutter_eff(cfg_g);
            ph = dim_eff(cfg_h) + 2 * gutter_eff(cfg_g);
            frame_loads = dim_eff(cfg_w) * dim_eff(cfg_h);
            // load only the start of a large frame
            if (frame_loads > MAX_FRAME_LOAD) frame_loads = MAX_FRAME_LOAD;
            // now and then load only part of a frame
            if ($urandom_range(0, 9) == 0) frame_loads = $urandom_range(0, frame_loads);
            repeat (frame_loads) push_pixel(MODE_LOAD, $urandom());
            // large padded frames are left part-way, so the next phase restarts mid-frame
            emit_reqs = (pw * ph <= 400) ? pw * ph + $urandom_range(0, pw)
                                         : $urandom_range(50, 200);
            repeat (emit_reqs) begin
                if ($urandom_range(0, 11) == 0) push_pixel(MODE_LOAD, $urandom());
                else push_pixel(MODE_EMIT, $urandom());
            end
            done_items += frame_loads + emit_reqs;
            drain_pipeline();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Result side: random back-pressure, compare each beat with the oldest expectation
    initial begin
        int unsigned hold_left;
        padded_px_t want;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 50)
                        $display("%0t: unexpected beat, expected none, ", $time,
                                 "actual rgba %h col %0d row %0d",
                                 m_tdata[31:0], m_tdata[40:32], m_tdata[49:41]);
                end else begin
                    want = expected_px.pop_front();
                    n_checked++;
                    if (m_tlast) n_frames++;
                    if (m_tdata[31:0] !== want.rgba || m_tdata[40:32] !== want.col ||
                        m_tdata[49:41] !== want.row || m_tlast !== want.last) begin
                        n_errors++;
                        if (n_errors <= 50)
                            $display("%0t: mismatch, expected rgba %h col %0d row %0d last %b, ",
                                     $time, want.rgba, want.col, want.row, want.last,
                                     "actual rgba %h col %0d row %0d last %b",
                                     m_tdata[31:0], m_tdata[40:32], m_tdata[49:41], m_tlast);
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                hold_left = rx_steady ? 0 : pick_gap(40);
                m_tready <= (hold_left == 0);
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= MODE_LOAD;
        s_tdata   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_small_border();
        test_register_saturation();
        test_counter_restart();
        test_random_frames();

        drain_pipeline();
        repeat (12) @(posedge aclk);
        $display("Covered %0d loads and %0d emit requests; ", n_loads, n_emits,
                 "%0d padded pixels checked, %0d frame ends.", n_checked, n_frames);
        $display("Geometries ranged from 1x1 to 256-wide and 256-tall, gutters 0 to 16, errors: %0d.",
                 n_errors);
        if (n_errors == 0) begin
            $display("image_edge_replicate_padder_top test passed");
        end else begin
            $display("image_edge_replicate_padder_top test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d pixels still expected.", expected_px.size());
        $display("image_edge_replicate_padder_top test failed");
        $finish;
    end

endmodule

FILE: image_edge_replicate_padder_top.f
src/iepad_pkg.sv
src/iepad_ram.sv
src/iepad_ctrl.sv
src/iepad_datapath.sv
src/image_edge_replicate_padder_top.sv
test/tb_image_edge_replicate_padder_top.sv
